>>> sv/kqs_pkg.sv
package kqs_pkg;

   localparam int MAX_ITEMS_DEF = 256;
   localparam int DATA_W        = 32;
   localparam int RANK_W        = 9;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 2;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_RANK = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] value;
      logic [RANK_W-1:0]        rank;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] selected;
      logic [STATUS_W-1:0]      status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PIVOT_RD,
      ST_PIVOT_LD,
      ST_RIGHT_RD,
      ST_RIGHT_EV,
      ST_LEFT_RD,
      ST_LEFT_EV,
      ST_PLACE
   } ctl_state_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_CLEAR,
      DP_APPEND,
      DP_START,
      DP_PIVOT_RD,
      DP_PIVOT_LD,
      DP_RD_RIGHT,
      DP_RD_LEFT,
      DP_R_DEC,
      DP_R_MOVE,
      DP_L_INC,
      DP_L_MOVE,
      DP_PLACE_DONE,
      DP_PLACE_HIGH,
      DP_PLACE_LOW
   } dp_op_type;

   typedef enum logic [1:0] {
      RSP_ZERO,
      RSP_FULL,
      RSP_BAD,
      RSP_PIVOT
   } rsp_kind_type;

   typedef struct packed {
      dp_op_type    op;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic store_full;
      logic rank_bad;
      logic lt;
      logic right_hit;
      logic left_hit;
      logic placed_eq;
      logic placed_gt;
   } dp_stat_type;

endpackage

>>> sv/kqs_datapath.sv
module kqs_datapath #(
   parameter int MAX_ITEMS = kqs_pkg::MAX_ITEMS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  kqs_pkg::req_type    req_data,
   input  kqs_pkg::dp_cmd_type cmd,
   output kqs_pkg::dp_stat_type stat,
   output kqs_pkg::rsp_type    rsp_data
);
   import kqs_pkg::*;

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

   logic signed [DATA_W-1:0] item_store_ff [MAX_ITEMS];
   logic signed [DATA_W-1:0] rdata_ff;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         low_ff, low_in;
   logic [IDX_W-1:0]         high_ff, high_in;
   logic [IDX_W-1:0]         left_ff, left_in;
   logic [IDX_W-1:0]         right_ff, right_in;
   logic [RANK_W-1:0]        rank_left_ff, rank_left_in;
   logic signed [DATA_W-1:0] pivot_ff, pivot_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     we;
   logic [IDX_W-1:0]         waddr;
   logic [IDX_W-1:0]         raddr;
   logic signed [DATA_W-1:0] wdata;
   logic [CNT_W-1:0]         placed;
   logic                     full;

   assign full   = (count_ff == CNT_W'(MAX_ITEMS));
   assign placed = CNT_W'(left_ff) - CNT_W'(low_ff) + CNT_W'(1);

   always_comb begin
      stat.store_full = full;
      stat.rank_bad   = (req_data.rank == '0) ||
                        (CMP_W'(req_data.rank) > CMP_W'(count_ff));
      stat.lt         = (left_ff < right_ff);
      stat.right_hit  = (pivot_ff > rdata_ff);
      stat.left_hit   = (rdata_ff > pivot_ff);
      stat.placed_eq  = (CMP_W'(placed) == CMP_W'(rank_left_ff));
      stat.placed_gt  = (CMP_W'(placed) > CMP_W'(rank_left_ff));
   end

   // memory port selection
   always_comb begin
      we    = 1'b0;
      waddr = left_ff;
      wdata = rdata_ff;
      case (cmd.op)
         DP_PIVOT_RD: raddr = low_ff;
         DP_RD_RIGHT: raddr = right_ff;
         default:     raddr = left_ff;
      endcase
      case (cmd.op)
         DP_APPEND: begin
            we    = !full;
            waddr = count_ff[IDX_W-1:0];
            wdata = req_data.value;
         end
         DP_R_MOVE: begin
            we = 1'b1;
         end
         DP_L_MOVE: begin
            we    = 1'b1;
            waddr = right_ff;
         end
         DP_PLACE_DONE, DP_PLACE_HIGH, DP_PLACE_LOW: begin
            we    = 1'b1;
            wdata = pivot_ff;
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      rank_left_in = rank_left_ff;
      pivot_in     = pivot_ff;
      case (cmd.op)
         DP_CLEAR:  count_in = '0;
         DP_APPEND: begin
            if (!full) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         DP_START: begin
            low_in       = '0;
            high_in      = IDX_W'(count_ff - CNT_W'(1));
            rank_left_in = req_data.rank;
         end
         DP_PIVOT_RD: begin
            left_in  = low_ff;
            right_in = high_ff;
         end
         DP_PIVOT_LD: pivot_in = rdata_ff;
         DP_R_DEC:    right_in = right_ff - IDX_W'(1);
         DP_R_MOVE:   left_in = left_ff + IDX_W'(1);
         DP_L_INC:    left_in = left_ff + IDX_W'(1);
         DP_L_MOVE:   right_in = right_ff - IDX_W'(1);
         DP_PLACE_HIGH: high_in = left_ff - IDX_W'(1);
         DP_PLACE_LOW: begin
            low_in       = left_ff + IDX_W'(1);
            rank_left_in = rank_left_ff - RANK_W'(placed);
         end
         default: count_in = count_ff;
      endcase
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.rsp_load) begin
         case (cmd.rsp_kind)
            RSP_FULL:  rsp_data_in = '{selected: '0, status: STATUS_FULL};
            RSP_BAD:   rsp_data_in = '{selected: '0, status: STATUS_BAD_RANK};
            RSP_PIVOT: rsp_data_in = '{selected: pivot_ff, status: STATUS_OK};
            default:   rsp_data_in = '{selected: '0, status: STATUS_OK};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         item_store_ff[waddr] <= wdata;
      end
      rdata_ff <= item_store_ff[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      low_ff       <= low_in;
      high_ff      <= high_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      rank_left_ff <= rank_left_in;
      pivot_ff     <= pivot_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_data = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("item count above capacity");

   a_scan_ordered: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_R_DEC || cmd.op == DP_R_MOVE || cmd.op == DP_L_INC ||
       cmd.op == DP_L_MOVE) |-> (left_ff < right_ff))
      else $error("scan step with crossed pointers");

   a_place_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_PLACE_DONE || cmd.op == DP_PLACE_HIGH || cmd.op == DP_PLACE_LOW)
      |-> (left_ff >= low_ff && left_ff <= high_ff))
      else $error("pivot placed outside live range");

endmodule

>>> sv/kqs_ctrl.sv
module kqs_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [kqs_pkg::CMD_W-1:0]  req_cmd,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  kqs_pkg::dp_stat_type       stat,
   output kqs_pkg::dp_cmd_type        cmd
);
   import kqs_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          req_fire;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '{op: DP_NONE, rsp_load: 1'b0, rsp_kind: RSP_ZERO};
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_cmd)
                  CMD_CLEAR: begin
                     cmd = '{op: DP_CLEAR, rsp_load: 1'b1, rsp_kind: RSP_ZERO};
                  end
                  CMD_APPEND: begin
                     cmd = '{op: DP_APPEND, rsp_load: 1'b1,
                             rsp_kind: stat.store_full ? RSP_FULL : RSP_ZERO};
                  end
                  CMD_QUERY: begin
                     if (stat.rank_bad) begin
                        cmd = '{op: DP_NONE, rsp_load: 1'b1, rsp_kind: RSP_BAD};
                     end else begin
                        cmd.op   = DP_START;
                        state_in = ST_PIVOT_RD;
                     end
                  end
                  default: begin
                     cmd = '{op: DP_NONE, rsp_load: 1'b1, rsp_kind: RSP_ZERO};
                  end
               endcase
            end
         end
         ST_PIVOT_RD: begin
            cmd.op   = DP_PIVOT_RD;
            state_in = ST_PIVOT_LD;
         end
         ST_PIVOT_LD: begin
            cmd.op   = DP_PIVOT_LD;
            state_in = ST_RIGHT_RD;
         end
         ST_RIGHT_RD: begin
            if (stat.lt) begin
               cmd.op   = DP_RD_RIGHT;
               state_in = ST_RIGHT_EV;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_RIGHT_EV: begin
            if (stat.right_hit) begin
               cmd.op   = DP_R_DEC;
               state_in = ST_RIGHT_RD;
            end else begin
               cmd.op   = DP_R_MOVE;
               state_in = ST_LEFT_RD;
            end
         end
         ST_LEFT_RD: begin
            if (stat.lt) begin
               cmd.op   = DP_RD_LEFT;
               state_in = ST_LEFT_EV;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_LEFT_EV: begin
            if (stat.left_hit) begin
               cmd.op   = DP_L_INC;
               state_in = ST_LEFT_RD;
            end else begin
               cmd.op   = DP_L_MOVE;
               state_in = ST_RIGHT_RD;
            end
         end
         ST_PLACE: begin
            if (stat.placed_eq) begin
               cmd      = '{op: DP_PLACE_DONE, rsp_load: 1'b1, rsp_kind: RSP_PIVOT};
               state_in = ST_IDLE;
            end else if (stat.placed_gt) begin
               cmd.op   = DP_PLACE_HIGH;
               state_in = ST_PIVOT_RD;
            end else begin
               cmd.op   = DP_PLACE_LOW;
               state_in = ST_PIVOT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a waiting beat");

   a_query_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_cmd == CMD_QUERY && !stat.rank_bad) |=> !rsp_valid_ff)
      else $error("result shown before the search finished");

   a_eval_ordered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RIGHT_EV || state_ff == ST_LEFT_EV) |-> stat.lt)
      else $error("compare step with crossed pointers");

endmodule

>>> sv/kth_largest_quickselect_core.sv
// Clear, append, unused and bad-rank commands: the result beat is registered in the cycle
// after accept; one such command per cycle while the result side keeps up. Query: each
// partition pass reads and loads the pivot, alternates right and left scan steps (a store
// read, then a compare) and places the pivot; passes repeat until the pivot hits the rank.
// Reset (synchronous, active high) empties the store count and idles the controller; store
// contents are not cleared and are never read before being written.
module kth_largest_quickselect_core #(
   parameter int MAX_ITEMS = kqs_pkg::MAX_ITEMS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  kqs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output kqs_pkg::rsp_type rsp_data
);
   import kqs_pkg::*;

   // command and status between the sequencer and the datapath
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // sequencer: takes request beats, walks the partition passes, issues result beats
   kqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_data.cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   // datapath: value store, range and scan pointers, pivot, result register
   kqs_datapath #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (dp_cmd),
      .stat     (dp_stat),
      .rsp_data (rsp_data)
   );

endmodule
